// ===== rtl/blsr_pkg.sv =====
// Shared constants, types and state codes for the blob-to-line-segment raster unit.
package blsr_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int QUEUE_DEPTH = 4096;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int SZ_W = 7;
  localparam int G_W = 16;

  typedef enum logic [1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_THICK = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_ADV,
    ST_Q_RD,
    ST_Q_WAIT,
    ST_N_RD,
    ST_N_CHK,
    ST_L_SETUP,
    ST_L_ROW,
    ST_L_RD,
    ST_L_WR,
    ST_O_RD,
    ST_O_ACC,
    ST_O_SEND
  } state_t;

  function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v,
                                                 input logic [SZ_W-1:0] hi);
    logic [SZ_W-1:0] r;
    r = v;
    if (v == '0) r = SZ_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/blsr_if.sv =====
// Request channel interfaces: input columns, output rows and configuration writes.
interface blsr_in_if;
  import blsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MAX_ROWS-1:0] column_bits;
  logic                last_column;
  modport source(output valid, column_bits, last_column, input ready);
  modport sink(input valid, column_bits, last_column, output ready);
endinterface

interface blsr_out_if;
  import blsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [MAX_COLS-1:0] row_bits;
  logic [ROW_W-1:0]    row_index;
  logic                last_row;
  modport source(output valid, row_bits, row_index, last_row, input ready);
  modport sink(input valid, row_bits, row_index, last_row, output ready);
endinterface

interface blsr_cfg_if;
  import blsr_pkg::*;
  logic            valid;
  logic            ready;
  cfg_idx_t        index;
  logic [SZ_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/blob_to_line_segment_raster_unit.sv =====
// Top level: column store, flood-fill sequencer, line rasterizer and row output.
// Columns are taken one per cycle. On the final column the unit is busy with the
// frame: a copy sweep that fills the work memory and clears the drawing memory, a
// pixel scan, a flood fill with four neighbor checks per filled pixel through the
// work memory read port, per blob a line pass over each spanned column, then for
// each output row a gather of bits from the column-organized drawing memory.
// Input is not accepted until the last output row has been taken.
module blob_to_line_segment_raster_unit
  import blsr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  blsr_in_if.sink    in_ch,
  blsr_out_if.source out_ch,
  blsr_cfg_if.sink   cfg_ch
);

  localparam logic [MAX_ROWS-1:0] ONES = '1;

  state_t state_r, state_nxt;
  logic [SZ_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [SZ_W-1:0] rows_r, cols_r, thick_r;
  logic [SZ_W-1:0] m_r, m_nxt, n_r, n_nxt;
  logic [COL_W-1:0] j_r, j_nxt;
  logic [ROW_W-1:0] i_r, i_nxt;
  logic [QA_W:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [ROW_W-1:0] pr_r, pr_nxt, nr_r, nr_nxt;
  logic [COL_W-1:0] pc_r, pc_nxt, nc_r, nc_nxt;
  logic [1:0] k_r, k_nxt;
  logic [ROW_W-1:0] a2_r, a2_nxt;
  logic [SZ_W-1:0] b2_r, b2_nxt;
  logic signed [SZ_W-1:0] da_r, da_nxt;
  logic [SZ_W-1:0] d_r, d_nxt;
  logic [ROW_W-1:0] amin_r, amin_nxt, amax_r, amax_nxt, lr_r, lr_nxt;
  logic [SZ_W-1:0] lc_r, lc_nxt;
  logic signed [G_W-1:0] g_r, g_nxt, gc_r, gc_nxt;
  logic [MAX_ROWS-1:0] cmask_r, cmask_nxt;
  logic [ROW_W-1:0] orow_r, orow_nxt;
  logic [COL_W-1:0] oc_r, oc_nxt;
  logic [MAX_COLS-1:0] rowacc_r, rowacc_nxt;

  logic img_we, img_re, wk_we, wk_re, dr_we, dr_re, q_we, q_re;
  logic [COL_W-1:0] img_wa, img_ra, wk_wa, wk_ra, dr_wa, dr_ra;
  logic [MAX_ROWS-1:0] img_wd, img_q, wk_wd, wk_q, dr_wd, dr_q;
  logic [QA_W-1:0] q_wa, q_ra;
  logic [ROW_W+COL_W-1:0] q_wd, q_q;

  logic [MAX_ROWS-1:0] rowmask, smask;
  logic [SZ_W-1:0] bb, dd;
  logic [ROW_W-1:0] amin_w;
  logic signed [SZ_W:0] off_w;
  logic signed [G_W-1:0] g0_w, gda, gmd, gdd;
  logic hit, nvalid;
  logic [ROW_W-1:0] ncr;
  logic [COL_W-1:0] ncc;
  logic [SZ_W:0] top;
  logic scan_last_row, scan_last_col;

  blsr_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_COLS)) u_img (
    .clk, .we(img_we), .wa(img_wa), .wd(img_wd), .re(img_re), .ra(img_ra), .rq(img_q));
  blsr_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_COLS)) u_work (
    .clk, .we(wk_we), .wa(wk_wa), .wd(wk_wd), .re(wk_re), .ra(wk_ra), .rq(wk_q));
  blsr_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_COLS)) u_drawn (
    .clk, .we(dr_we), .wa(dr_wa), .wd(dr_wd), .re(dr_re), .ra(dr_ra), .rq(dr_q));
  blsr_ram #(.WIDTH(ROW_W + COL_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .we(q_we), .wa(q_wa), .wd(q_wd), .re(q_re), .ra(q_ra), .rq(q_q));

  assign rowmask = ~(ONES << m_r);
  assign scan_last_row = ({1'b0, i_r} == m_r - SZ_W'(1));
  assign scan_last_col = ({1'b0, j_r} == n_r - SZ_W'(1));

  // line setup
  assign bb = (b2_r == {1'b0, j_r}) ? b2_r + SZ_W'(1) : b2_r;
  assign dd = bb - {1'b0, j_r};
  assign amin_w = (a2_r < i_r) ? a2_r : i_r;
  assign off_w = $signed({2'b00, amin_w}) - $signed({2'b00, i_r});
  assign g0_w = G_W'(-($signed({1'b0, dd}) * off_w));

  // cell hit and stroke mask
  assign gda = g_r + G_W'(da_r);
  assign gmd = g_r - $signed(G_W'(d_r));
  assign gdd = gda - $signed(G_W'(d_r));
  assign hit = (g_r > 0 && (gda < 0 || gmd < 0 || gdd < 0)) ||
               (g_r < 0 && (gda > 0 || gmd > 0 || gdd > 0));
  assign top = {2'b00, lr_r} + {1'b0, thick_r};
  assign smask = (ONES << lr_r) & ((top >= (SZ_W + 1)'(MAX_ROWS)) ? ONES :
                 ~(ONES << top[ROW_W-1:0])) & rowmask;

  // neighbor in the order row+1, col+1, row-1, col-1
  always_comb begin
    nvalid = 1'b0;
    ncr = pr_r;
    ncc = pc_r;
    unique case (k_r)
      2'd0: begin
        ncr = pr_r + ROW_W'(1);
        nvalid = ({1'b0, pr_r} + SZ_W'(1)) < m_r;
      end
      2'd1: begin
        ncc = pc_r + COL_W'(1);
        nvalid = ({1'b0, pc_r} + SZ_W'(1)) < n_r;
      end
      2'd2: begin
        ncr = pr_r - ROW_W'(1);
        nvalid = pr_r != '0;
      end
      default: begin
        ncc = pc_r - COL_W'(1);
        nvalid = pc_r != '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    col_cnt_nxt = col_cnt_r;
    m_nxt = m_r;
    n_nxt = n_r;
    j_nxt = j_r;
    i_nxt = i_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    pr_nxt = pr_r;
    pc_nxt = pc_r;
    nr_nxt = nr_r;
    nc_nxt = nc_r;
    k_nxt = k_r;
    a2_nxt = a2_r;
    b2_nxt = b2_r;
    da_nxt = da_r;
    d_nxt = d_r;
    amin_nxt = amin_r;
    amax_nxt = amax_r;
    lr_nxt = lr_r;
    lc_nxt = lc_r;
    g_nxt = g_r;
    gc_nxt = gc_r;
    cmask_nxt = cmask_r;
    orow_nxt = orow_r;
    oc_nxt = oc_r;
    rowacc_nxt = rowacc_r;
    img_we = 1'b0; img_wa = col_cnt_r[COL_W-1:0]; img_wd = in_ch.column_bits;
    img_re = 1'b0; img_ra = j_r;
    wk_we = 1'b0; wk_wa = j_r; wk_wd = img_q & rowmask;
    wk_re = 1'b0; wk_ra = j_r;
    dr_we = 1'b0; dr_wa = j_r; dr_wd = '0;
    dr_re = 1'b0; dr_ra = lc_r[COL_W-1:0];
    q_we = 1'b0; q_wa = tail_r[QA_W-1:0]; q_wd = {nr_r, nc_r};
    q_re = 1'b0; q_ra = head_r[QA_W-1:0];
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (col_cnt_r < SZ_W'(MAX_COLS)) begin
            img_we = 1'b1;
            col_cnt_nxt = col_cnt_r + SZ_W'(1);
          end
          if (in_ch.last_column) begin
            col_cnt_nxt = '0;
            m_nxt = clamp_size(rows_r, SZ_W'(MAX_ROWS));
            n_nxt = clamp_size(cols_r, SZ_W'(MAX_COLS));
            j_nxt = '0;
            state_nxt = ST_CP_RD;
          end
        end
      end
      ST_CP_RD: begin
        img_re = 1'b1;
        state_nxt = ST_CP_WR;
      end
      ST_CP_WR: begin
        wk_we = 1'b1;
        dr_we = 1'b1;
        if (scan_last_col) begin
          j_nxt = '0;
          i_nxt = '0;
          state_nxt = ST_SC_RD;
        end else begin
          j_nxt = j_r + COL_W'(1);
          state_nxt = ST_CP_RD;
        end
      end
      ST_SC_RD: begin
        wk_re = 1'b1;
        state_nxt = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (wk_q[i_r]) begin
          wk_we = 1'b1;
          wk_wd = wk_q & ~(ONES << 0 & (MAX_ROWS'(1) << i_r));
          q_we = 1'b1;
          q_wa = '0;
          q_wd = {i_r, j_r};
          head_nxt = '0;
          tail_nxt = (QA_W + 1)'(1);
          a2_nxt = i_r;
          b2_nxt = {1'b0, j_r};
          state_nxt = ST_Q_RD;
        end else if (scan_last_row) begin
          state_nxt = ST_SC_ADV;
        end else begin
          i_nxt = i_r + ROW_W'(1);
        end
      end
      ST_SC_ADV: begin
        if (scan_last_row) begin
          i_nxt = '0;
          if (scan_last_col) begin
            orow_nxt = '0;
            oc_nxt = '0;
            rowacc_nxt = '0;
            state_nxt = ST_O_RD;
          end else begin
            j_nxt = j_r + COL_W'(1);
            state_nxt = ST_SC_RD;
          end
        end else begin
          i_nxt = i_r + ROW_W'(1);
          state_nxt = ST_SC_RD;
        end
      end
      ST_Q_RD: begin
        if (head_r == tail_r) begin
          state_nxt = ST_L_SETUP;
        end else begin
          q_re = 1'b1;
          head_nxt = head_r + (QA_W + 1)'(1);
          state_nxt = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        pr_nxt = q_q[ROW_W+COL_W-1:COL_W];
        pc_nxt = q_q[COL_W-1:0];
        k_nxt = '0;
        state_nxt = ST_N_RD;
      end
      ST_N_RD: begin
        if (nvalid) begin
          wk_re = 1'b1;
          wk_ra = ncc;
          nr_nxt = ncr;
          nc_nxt = ncc;
          state_nxt = ST_N_CHK;
        end else if (k_r == 2'd3) begin
          state_nxt = ST_Q_RD;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_N_CHK: begin
        if (wk_q[nr_r]) begin
          wk_we = 1'b1;
          wk_wa = nc_r;
          wk_wd = wk_q & ~(MAX_ROWS'(1) << nr_r);
          q_we = 1'b1;
          tail_nxt = tail_r + (QA_W + 1)'(1);
          if ({1'b0, nc_r} > b2_r) begin
            b2_nxt = {1'b0, nc_r};
            a2_nxt = nr_r;
          end
        end
        k_nxt = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? ST_Q_RD : ST_N_RD;
      end
      ST_L_SETUP: begin
        b2_nxt = bb;
        d_nxt = dd;
        da_nxt = $signed({1'b0, a2_r}) - $signed({1'b0, i_r});
        amin_nxt = amin_w;
        amax_nxt = (a2_r < i_r) ? i_r : a2_r;
        lr_nxt = amin_w;
        lc_nxt = {1'b0, j_r};
        g_nxt = g0_w;
        gc_nxt = g0_w;
        cmask_nxt = '0;
        state_nxt = ST_L_ROW;
      end
      ST_L_ROW: begin
        if (hit) cmask_nxt = cmask_r | smask;
        if (lr_r == amax_r) begin
          state_nxt = ST_L_RD;
        end else begin
          lr_nxt = lr_r + ROW_W'(1);
          g_nxt = gmd;
        end
      end
      ST_L_RD: begin
        dr_re = 1'b1;
        state_nxt = ST_L_WR;
      end
      ST_L_WR: begin
        dr_we = lc_r < n_r;
        dr_wa = lc_r[COL_W-1:0];
        dr_wd = dr_q | cmask_r;
        if (lc_r == b2_r) begin
          state_nxt = ST_SC_ADV;
        end else begin
          lc_nxt = lc_r + SZ_W'(1);
          gc_nxt = gc_r + G_W'(da_r);
          g_nxt = gc_r + G_W'(da_r);
          lr_nxt = amin_r;
          cmask_nxt = '0;
          state_nxt = ST_L_ROW;
        end
      end
      ST_O_RD: begin
        dr_re = 1'b1;
        dr_ra = oc_r;
        state_nxt = ST_O_ACC;
      end
      ST_O_ACC: begin
        rowacc_nxt[oc_r] = ({1'b0, oc_r} < n_r) ? dr_q[orow_r] : 1'b0;
        if (oc_r == COL_W'(MAX_COLS - 1)) begin
          state_nxt = ST_O_SEND;
        end else begin
          oc_nxt = oc_r + COL_W'(1);
          state_nxt = ST_O_RD;
        end
      end
      ST_O_SEND: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if ({1'b0, orow_r} == m_r - SZ_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            orow_nxt = orow_r + ROW_W'(1);
            oc_nxt = '0;
            rowacc_nxt = '0;
            state_nxt = ST_O_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.row_bits = rowacc_r;
  assign out_ch.row_index = orow_r;
  assign out_ch.last_row = ({1'b0, orow_r} == m_r - SZ_W'(1));
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_cnt_r <= '0;
      rows_r <= SZ_W'(MAX_ROWS);
      cols_r <= SZ_W'(MAX_COLS);
      thick_r <= SZ_W'(1);
      m_r <= SZ_W'(MAX_ROWS);
      n_r <= SZ_W'(MAX_COLS);
      head_r <= '0;
      tail_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_cnt_r <= col_cnt_nxt;
      m_r <= m_nxt;
      n_r <= n_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_ROWS:  rows_r <= cfg_ch.data;
          CFG_COLS:  cols_r <= cfg_ch.data;
          CFG_THICK: thick_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    i_r <= i_nxt;
    pr_r <= pr_nxt;
    pc_r <= pc_nxt;
    nr_r <= nr_nxt;
    nc_r <= nc_nxt;
    k_r <= k_nxt;
    a2_r <= a2_nxt;
    b2_r <= b2_nxt;
    da_r <= da_nxt;
    d_r <= d_nxt;
    amin_r <= amin_nxt;
    amax_r <= amax_nxt;
    lr_r <= lr_nxt;
    lc_r <= lc_nxt;
    g_r <= g_nxt;
    gc_r <= gc_nxt;
    cmask_r <= cmask_nxt;
    orow_r <= orow_nxt;
    oc_r <= oc_nxt;
    rowacc_r <= rowacc_nxt;
  end

  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and output active together");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("fill queue head passed tail");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_row |=> in_ch.ready)
    else $error("unit not idle after last row");

endmodule

// ===== rtl/blsr_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
module blsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rq
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (re) rq <= mem[ra];
  end

endmodule
